>>> rtl/asinh_grad_reciprocal_cosh_unit_macros.svh
// Assertion macros used by the asinh gradient top level.
// Needs signals clk and rst_n in the including scope.
`ifndef ASINH_GRAD_RECIPROCAL_COSH_UNIT_MACROS_SVH
`define ASINH_GRAD_RECIPROCAL_COSH_UNIT_MACROS_SVH

// same-cycle implication
`define AGRC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AGRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/agrc_pkg.sv
// Package for the asinh gradient unit: constants and inter-module structs.
// No dependencies.
`default_nettype none

package agrc_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int Y_FRAC_DEF     = 11;
    localparam int SERIES_TERMS   = 12;
    localparam int RECIP_SHIFT    = 34;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    // 31 * ln2 in Q30: at or above this e^-|y| rounds to zero
    localparam logic [63:0] SAT_LIM = 64'd23072094658;

    typedef struct packed {
        logic               vld;
        logic [30:0]        term;
        logic signed [32:0] sum;
        logic [29:0]        r;
    } agrc_ser_t;

    typedef struct packed {
        logic        vld;
        logic [61:0] num;
        logic [31:0] den;
    } agrc_div_t;

endpackage

`default_nettype wire

>>> rtl/asinh_grad_reciprocal_cosh_unit.sv
// Top level of the asinh gradient unit: grad_out = grad_in / cosh(y_value).
// Depends on agrc_pkg, agrc_term, agrc_div and the assertion macro header.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   in      | in_valid / in_ready | y_value (Q4.11), grad_in (Q8.8)
//   out     | out_valid/out_ready | grad_out (Q8.8, round to nearest)
//
// One request per cycle sustained while the skid register is empty; the path
// from in to out has 62 register stages. Depth is set by the twelve series
// terms (3 stages each) and the 16-stage sech divider. Reset clears valid
// bits only. A stalled output parks one result in a skid register; the whole
// pipe freezes only while the skid is full, so in_ready is a register output.
`default_nettype none

module asinh_grad_reciprocal_cosh_unit
    import agrc_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int Y_FRAC_BITS = Y_FRAC_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] y_value,
    input  logic signed [DATA_WIDTH-1:0] grad_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] grad_out
);

`include "asinh_grad_reciprocal_cosh_unit_macros.svh"

    localparam int DW     = DATA_WIDTH;
    localparam int AQW    = DW + 30 - Y_FRAC_BITS;
    localparam int CW     = (AQW > 35) ? AQW : 35;
    localparam int SIDE_W = 1 + 5 + DW;
    localparam int PW     = DW + 31;

    // global advance: frozen only while the skid holds a result
    logic en;
    logic skid_vld_reg, out_vld_reg;
    logic [DW-1:0] skid_data_reg, out_data_reg;

    assign en       = !skid_vld_reg;
    assign in_ready = en;

    // stage 0: input capture
    logic vld0_reg;
    logic [DW-1:0] y0_reg, dy0_reg;

    // stage 1: |y| in Q30, overflow of the exponent range
    logic vld1_reg, sat1_reg;
    logic [34:0] aq1_reg;
    logic [DW-1:0] dy1_reg;
    logic [DW-1:0] ymag;
    logic [CW-1:0] aq_ext;

    // stages 2, 3: n = aq / ln2 by constant restoring steps
    logic vld2_reg, sat2_reg, vld3_reg, sat3_reg;
    logic [34:0] rem2_reg, rem2_next, rem3_next;
    logic [4:0] n2_reg, n2_next, n3_reg, n3_next;
    logic [29:0] r3_reg;
    logic [DW-1:0] dy2_reg, dy3_reg;

    always_comb
    begin
        ymag   = y0_reg[DW-1] ? DW'(~y0_reg + 1'b1) : y0_reg;
        aq_ext = CW'(ymag) << (30 - Y_FRAC_BITS);

        rem2_next = aq1_reg;
        n2_next   = '0;
        for (int b = 4; b >= 3; b--)
        begin
            if (rem2_next >= 35'(LN2_Q30 << b))
            begin
                rem2_next  = rem2_next - 35'(LN2_Q30 << b);
                n2_next[b] = 1'b1;
            end
        end

        rem3_next = rem2_reg;
        n3_next   = n2_reg;
        for (int b = 2; b >= 0; b--)
        begin
            if (rem3_next >= 35'(LN2_Q30 << b))
            begin
                rem3_next  = rem3_next - 35'(LN2_Q30 << b);
                n3_next[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y0_reg   <= y_value;
            dy0_reg  <= grad_in;
            aq1_reg  <= aq_ext[34:0];
            sat1_reg <= (aq_ext >= CW'(SAT_LIM));
            dy1_reg  <= dy0_reg;
            rem2_reg <= rem2_next;
            n2_reg   <= n2_next;
            sat2_reg <= sat1_reg;
            dy2_reg  <= dy1_reg;
            r3_reg   <= rem3_next[29:0];
            n3_reg   <= n3_next;
            sat3_reg <= sat2_reg;
            dy3_reg  <= dy2_reg;
        end
    end

    // series for e^-r, one term per instance
    agrc_ser_t         ser  [SERIES_TERMS+1];
    logic [SIDE_W-1:0] side [SERIES_TERMS+1];

    assign ser[0].vld  = vld3_reg;
    assign ser[0].term = 31'(Q30_ONE);
    assign ser[0].sum  = $signed(33'(Q30_ONE));
    assign ser[0].r    = r3_reg;
    assign side[0]     = {sat3_reg, n3_reg, dy3_reg};

    genvar k;
    generate
        for (k = 1; k <= SERIES_TERMS; k++)
        begin : g_term
            agrc_term #(
                .K      (k),
                .SIDE_W (SIDE_W)
            ) u_term (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .s_in     (ser[k-1]),
                .side_in  (side[k-1]),
                .s_out    (ser[k]),
                .side_out (side[k])
            );
        end
    endgenerate

    // E = e^-|y| = P >> n with rounding
    logic e_vld_reg;
    logic [30:0] e_reg, e_next, p_w;
    logic [31:0] pr_w;
    logic [4:0] n_w;
    logic [DW-1:0] dye_reg;

    always_comb
    begin
        n_w  = side[SERIES_TERMS][DW +: 5];
        p_w  = ser[SERIES_TERMS].sum[32] ? '0 : ser[SERIES_TERMS].sum[30:0];
        pr_w = {1'b0, p_w} + (32'd1 << (n_w - 5'd1));
        if (side[SERIES_TERMS][SIDE_W-1])
        begin
            e_next = '0;
        end
        else if (n_w == 5'd0)
        begin
            e_next = p_w;
        end
        else
        begin
            e_next = 31'(pr_w >> n_w);
        end
    end

    // E2 = E^2 rounded, then numerator and denominator of sech
    logic e2_vld_reg, nd_vld_reg;
    logic [30:0] e2_reg, ee_reg;
    logic [61:0] e2_prod;
    logic [31:0] e2_sum, den_next;
    logic [61:0] num_reg;
    logic [31:0] den_reg;
    logic [DW-1:0] dye2_reg, dynd_reg;

    always_comb
    begin
        e2_prod  = {31'b0, e_reg} * {31'b0, e_reg};
        e2_sum   = 32'((e2_prod + 62'(Q30_ONE >> 1)) >> 30);
        den_next = 32'(Q30_ONE) + {1'b0, e2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg  <= 1'b0;
            e2_vld_reg <= 1'b0;
            nd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg  <= ser[SERIES_TERMS].vld;
            e2_vld_reg <= e_vld_reg;
            nd_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg    <= e_next;
            dye_reg  <= side[SERIES_TERMS][DW-1:0];
            e2_reg   <= e2_sum[30:0];
            ee_reg   <= e_reg;
            dye2_reg <= dye_reg;
            den_reg  <= den_next;
            num_reg  <= ({31'b0, ee_reg} << 31) + 62'(den_next >> 1);
            dynd_reg <= dye2_reg;
        end
    end

    // sech = (E << 31 + D/2) / D
    agrc_div_t div_in;
    logic div_vld;
    logic [30:0] div_quo;
    logic [DW-1:0] div_dy;

    assign div_in.vld = nd_vld_reg;
    assign div_in.num = num_reg;
    assign div_in.den = den_reg;

    agrc_div #(
        .SIDE_W (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .d_in     (div_in),
        .side_in  (dynd_reg),
        .vld_out  (div_vld),
        .quo_out  (div_quo),
        .side_out (div_dy)
    );

    // |dy| * sech, round, restore sign
    logic m_vld_reg, m_neg_reg, tail_vld_reg;
    logic [PW-1:0] m_prod_reg, m_rnd;
    logic [DW-1:0] dy_mag, tail_reg, tail_next;

    always_comb
    begin
        dy_mag    = div_dy[DW-1] ? DW'(~div_dy + 1'b1) : div_dy;
        m_rnd     = (m_prod_reg + PW'(Q30_ONE >> 1)) >> 30;
        tail_next = m_neg_reg ? DW'(~m_rnd[DW-1:0] + 1'b1) : m_rnd[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg    <= 1'b0;
            tail_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg    <= div_vld;
            tail_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_prod_reg <= {31'b0, dy_mag} * {DW'(0), div_quo};
            m_neg_reg  <= div_dy[DW-1];
            tail_reg   <= tail_next;
        end
    end

    // output register plus skid
    logic push, pop;

    assign push = en && tail_vld_reg;
    assign pop  = out_vld_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_vld_reg)
            begin
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_vld_reg)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= tail_reg;
            end
        end
        else if (push)
        begin
            if (out_vld_reg)
            begin
                skid_data_reg <= tail_reg;
            end
            else
            begin
                out_data_reg <= tail_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign grad_out  = out_data_reg;

    `AGRC_ASSERT_IMPLY(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid full with empty output")
    `AGRC_ASSERT_NEXT(a_stall_fills_skid, out_vld_reg && !out_ready && push, skid_vld_reg, "stalled result lost")
    `AGRC_ASSERT_IMPLY(a_exp_range, e_vld_reg, e_reg <= 31'(Q30_ONE), "e^-|y| above one")
    `AGRC_ASSERT_IMPLY(a_sech_range, div_vld, div_quo <= 31'(Q30_ONE), "sech above one")

endmodule

`default_nettype wire

>>> rtl/agrc_term.sv
// One Taylor term of e^-r: term*r, reciprocal divide by K, accumulate.
// Three register stages. Depends on agrc_pkg.
`default_nettype none

module agrc_term
    import agrc_pkg::*;
#(
    parameter int K      = 1,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  agrc_ser_t         s_in,
    input  logic [SIDE_W-1:0] side_in,
    output agrc_ser_t         s_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / K;
    localparam logic [34:0] RECIP_C = 35'(RECIP);

    logic                vld1_reg, vld2_reg, vld3_reg;
    logic [29:0]         v1_reg, v2_reg, q0_reg;
    logic signed [32:0]  sum1_reg, sum2_reg, sum3_reg;
    logic [29:0]         r1_reg, r2_reg, r3_reg;
    logic [29:0]         q3_reg;
    logic [SIDE_W-1:0]   side1_reg, side2_reg, side3_reg;

    logic [60:0] prod1;
    logic [64:0] prod2;
    logic [33:0] q0k, rem;
    logic [29:0] q_next;
    logic signed [32:0] sum_next;

    always_comb
    begin
        prod1 = {30'b0, s_in.term} * {31'b0, s_in.r};
        prod2 = {35'b0, v1_reg} * {30'b0, RECIP_C};
        q0k   = {4'b0, q0_reg} * 34'(K);
        rem   = {4'b0, v2_reg} - q0k;
        // estimate is at most one low
        q_next = (rem >= 34'(K)) ? q0_reg + 30'd1 : q0_reg;
        if (K % 2 == 1)
        begin
            sum_next = sum2_reg - $signed({3'b0, q_next});
        end
        else
        begin
            sum_next = sum2_reg + $signed({3'b0, q_next});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= s_in.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg    <= prod1[59:30];
            sum1_reg  <= s_in.sum;
            r1_reg    <= s_in.r;
            side1_reg <= side_in;
            v2_reg    <= v1_reg;
            q0_reg    <= prod2[RECIP_SHIFT+29:RECIP_SHIFT];
            sum2_reg  <= sum1_reg;
            r2_reg    <= r1_reg;
            side2_reg <= side1_reg;
            q3_reg    <= q_next;
            sum3_reg  <= sum_next;
            r3_reg    <= r2_reg;
            side3_reg <= side2_reg;
        end
    end

    assign s_out.vld  = vld3_reg;
    assign s_out.term = {1'b0, q3_reg};
    assign s_out.sum  = sum3_reg;
    assign s_out.r    = r3_reg;
    assign side_out   = side3_reg;

endmodule

`default_nettype wire

>>> rtl/agrc_div.sv
// Pipelined restoring divider, two quotient bits per stage, 31-bit quotient.
// Depends on agrc_pkg.
`default_nettype none

module agrc_div
    import agrc_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  agrc_div_t         d_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [30:0]       quo_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int QBITS = 31;
    localparam int STEPS = 2;
    localparam int NSTG  = (QBITS + STEPS - 1) / STEPS;

    logic              vld_reg  [NSTG];
    logic [31:0]       rem_reg  [NSTG];
    logic [30:0]       quo_reg  [NSTG];
    logic [61:0]       num_reg  [NSTG];
    logic [31:0]       den_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stg
            localparam int BIT0 = QBITS - 1 - STEPS * s;
            localparam int BIT1 = BIT0 - 1;
            localparam int IDX1 = (BIT1 >= 0) ? BIT1 : 0;

            logic              vld_i;
            logic [31:0]       rem_i, rem_a, rem_b;
            logic [30:0]       quo_i, quo_a, quo_b;
            logic [61:0]       num_i;
            logic [31:0]       den_i;
            logic [SIDE_W-1:0] side_i;
            logic [32:0]       tr_a, tr_b;

            if (s == 0)
            begin : g_first
                assign vld_i  = d_in.vld;
                assign rem_i  = {1'b0, d_in.num[61:31]};
                assign quo_i  = '0;
                assign num_i  = d_in.num;
                assign den_i  = d_in.den;
                assign side_i = side_in;
            end
            else
            begin : g_next
                assign vld_i  = vld_reg[s-1];
                assign rem_i  = rem_reg[s-1];
                assign quo_i  = quo_reg[s-1];
                assign num_i  = num_reg[s-1];
                assign den_i  = den_reg[s-1];
                assign side_i = side_reg[s-1];
            end

            always_comb
            begin
                tr_a  = {rem_i, num_i[BIT0]};
                quo_a = quo_i;
                if (tr_a >= {1'b0, den_i})
                begin
                    rem_a       = 32'(tr_a - {1'b0, den_i});
                    quo_a[BIT0] = 1'b1;
                end
                else
                begin
                    rem_a = tr_a[31:0];
                end
                tr_b  = {rem_a, num_i[IDX1]};
                quo_b = quo_a;
                rem_b = rem_a;
                if (BIT1 >= 0)
                begin
                    if (tr_b >= {1'b0, den_i})
                    begin
                        rem_b       = 32'(tr_b - {1'b0, den_i});
                        quo_b[IDX1] = 1'b1;
                    end
                    else
                    begin
                        rem_b = tr_b[31:0];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= vld_i;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_b;
                    quo_reg[s]  <= quo_b;
                    num_reg[s]  <= num_i;
                    den_reg[s]  <= den_i;
                    side_reg[s] <= side_i;
                end
            end
        end
    endgenerate

    assign vld_out  = vld_reg[NSTG-1];
    assign quo_out  = quo_reg[NSTG-1];
    assign side_out = side_reg[NSTG-1];

endmodule

`default_nettype wire
